@@ design/atrp_pkg.sv @@
package atrp_pkg;

  localparam int FRAC_SHIFT = 12;
  localparam int TABLE_LEN  = 24;
  localparam int TAB_W      = 22;
  localparam int Z_W        = 27;
  localparam int ANGLE_FRAC = 16;
  localparam int ROLL_W     = 16;
  localparam int PITCH_W    = 15;
  localparam int ROLL_LIMIT  = 18000;
  localparam int PITCH_LIMIT = 9000;

  localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(180 * 65536);
  localparam logic [ANGLE_FRAC-1:0] ROUND_HALF = ANGLE_FRAC'(32768);

  localparam logic [TAB_W-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0
  };

endpackage

@@ design/atrp_sqrt.sv @@
module atrp_sqrt #(
  parameter int IN_W   = 24,
  parameter int SIDE_W = 36
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  input  logic [IN_W-1:0]                             in_sum,
  input  logic [SIDE_W-1:0]                           in_side,
  output logic                                        out_valid,
  output logic [IN_W/2+atrp_pkg::FRAC_SHIFT-1:0]      out_root,
  output logic [SIDE_W-1:0]                           out_side
);

  localparam int ROOT_W = IN_W / 2 + atrp_pkg::FRAC_SHIFT;
  localparam int V_W    = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  logic              v_r    [0:ROOT_W];
  logic [IN_W-1:0]   sum_r  [0:ROOT_W];
  logic [REM_W-1:0]  rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0] root_r [0:ROOT_W];
  logic [SIDE_W-1:0] side_r [0:ROOT_W];

  assign v_r[0]    = in_valid;
  assign sum_r[0]  = in_sum;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign side_r[0] = in_side;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int P = ROOT_W - 1 - k;
    logic [V_W-1:0]    vfull;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    always_comb begin
      vfull    = {sum_r[k], {(2 * atrp_pkg::FRAC_SHIFT){1'b0}}};
      rem_sh   = {rem_r[k][ROOT_W-1:0], vfull[2*P +: 2]};
      trial    = {root_r[k], 2'b01};
      take     = (rem_sh >= trial);
      rem_nxt  = take ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[k][ROOT_W-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
      sum_r[k+1]  <= sum_r[k];
      rem_r[k+1]  <= rem_nxt;
      root_r[k+1] <= root_nxt;
      side_r[k+1] <= side_r[k];
    end
  end

  assign out_valid = v_r[ROOT_W];
  assign out_root  = root_r[ROOT_W];
  assign out_side  = side_r[ROOT_W];

endmodule

@@ design/atrp_cordic.sv @@
module atrp_cordic #(
  parameter int CW     = 28,
  parameter int STEPS  = 16,
  parameter int OUT_W  = 16,
  parameter int LIMIT  = 18000
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [CW-1:0]    in_x,
  input  logic signed [CW-1:0]    in_y,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_angle
);

  localparam int NSTEP  = (STEPS > atrp_pkg::TABLE_LEN) ? atrp_pkg::TABLE_LEN : STEPS;
  localparam int Z_W    = atrp_pkg::Z_W;
  localparam int MAG_W  = Z_W - 1;
  localparam int PROD_W = MAG_W + 7;
  localparam int R_W    = PROD_W - atrp_pkg::ANGLE_FRAC;

  logic                 v_r  [0:NSTEP];
  logic                 zf_r [0:NSTEP];
  logic signed [CW-1:0] x_r  [0:NSTEP];
  logic signed [CW-1:0] y_r  [0:NSTEP];
  logic signed [Z_W-1:0] z_r [0:NSTEP];

  logic                 pre_zf_nxt;
  logic signed [CW-1:0] pre_x_nxt;
  logic signed [CW-1:0] pre_y_nxt;
  logic signed [Z_W-1:0] pre_z_nxt;

  always_comb begin
    pre_zf_nxt = (in_x == '0) && (in_y == '0);
    if (in_x < 0) begin
      pre_x_nxt = -in_x;
      pre_y_nxt = -in_y;
      pre_z_nxt = (in_y >= 0) ? atrp_pkg::HALF_TURN : -atrp_pkg::HALF_TURN;
    end else begin
      pre_x_nxt = in_x;
      pre_y_nxt = in_y;
      pre_z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
    zf_r[0] <= pre_zf_nxt;
    x_r[0]  <= pre_x_nxt;
    y_r[0]  <= pre_y_nxt;
    z_r[0]  <= pre_z_nxt;
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic signed [CW-1:0]  dx;
    logic signed [CW-1:0]  dy;
    logic signed [Z_W-1:0] ang;

    always_comb begin
      dx  = y_r[k] >>> k;
      dy  = x_r[k] >>> k;
      ang = $signed({{(Z_W - atrp_pkg::TAB_W){1'b0}}, atrp_pkg::ATAN_TAB[k]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
      zf_r[k+1] <= zf_r[k];
      if (y_r[k] >= 0) begin
        x_r[k+1] <= x_r[k] + dx;
        y_r[k+1] <= y_r[k] - dy;
        z_r[k+1] <= z_r[k] + ang;
      end else begin
        x_r[k+1] <= x_r[k] - dx;
        y_r[k+1] <= y_r[k] + dy;
        z_r[k+1] <= z_r[k] - ang;
      end
    end
  end

  logic                  rnd_v_r;
  logic                  rnd_zf_r;
  logic                  rnd_neg_r;
  logic [R_W-1:0]        rnd_mag_r;
  logic signed [Z_W-1:0] mag_full;
  logic [PROD_W-1:0]     prod;

  always_comb begin
    mag_full = z_r[NSTEP][Z_W-1] ? -z_r[NSTEP] : z_r[NSTEP];
    prod     = PROD_W'(mag_full[MAG_W-1:0]) * PROD_W'(100)
             + PROD_W'(atrp_pkg::ROUND_HALF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_v_r <= 1'b0;
    end else begin
      rnd_v_r <= v_r[NSTEP];
    end
    rnd_zf_r  <= zf_r[NSTEP];
    rnd_neg_r <= z_r[NSTEP][Z_W-1];
    rnd_mag_r <= prod[PROD_W-1:atrp_pkg::ANGLE_FRAC];
  end

  logic                  out_v_r;
  logic signed [OUT_W-1:0] angle_r;
  logic [R_W-1:0]        clamp_mag;
  logic signed [R_W:0]   signed_mag;
  logic signed [R_W:0]   angle_full;

  always_comb begin
    clamp_mag  = (rnd_mag_r > R_W'(LIMIT)) ? R_W'(LIMIT) : rnd_mag_r;
    signed_mag = $signed({1'b0, clamp_mag});
    if (rnd_zf_r) begin
      angle_full = '0;
    end else if (rnd_neg_r) begin
      angle_full = -signed_mag;
    end else begin
      angle_full = signed_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= rnd_v_r;
    end
    angle_r <= angle_full[OUT_W-1:0];
  end

  assign out_valid = out_v_r;
  assign out_angle = angle_r;

endmodule

@@ design/accel_tilt_roll_pitch_core.sv @@
// Roll and pitch from one three-axis accelerometer sample.
// Input: raise start with in_accel_x/y/z; the item is taken at an edge where
// start is high and busy is low. busy stays low: a new item may enter every cycle.
// Output: out_valid strobes for one cycle with out_roll_angle = atan2(y, z) and
// out_pitch_angle = atan2(-x, sqrt(y*y + z*z)), both in hundredths of a degree.
// An accepted item passes the input, squaring and sum registers, the square root
// (one bit per stage), then in each CORDIC lane the pre-rotation register, the
// rotation stages, rounding and output registers. Throughput: one item per cycle.
// Both CORDIC lanes work side by side on the same item, one rotation per stage.
// Items leave in the order they entered; nothing is held back or repeated.
// Reset clears every valid bit; items in flight are dropped and no strobe
// follows until a new item is taken.
// The receiver has no way to stall: each result is shown for exactly one cycle.
module accel_tilt_roll_pitch_core #(
  parameter int SAMPLE_WIDTH   = 12,
  parameter int ROTATION_STEPS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_accel_z,
  output logic                                 out_valid,
  output logic signed [atrp_pkg::ROLL_W-1:0]   out_roll_angle,
  output logic signed [atrp_pkg::PITCH_W-1:0]  out_pitch_angle
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int FRAC   = atrp_pkg::FRAC_SHIFT;
  localparam int SQ_W   = 2 * SW;
  localparam int ROOT_W = SW + FRAC;
  localparam int CW     = SW + FRAC + 4;
  localparam int SIDE_W = 3 * SW;

  assign busy = 1'b0;

  logic                 in_v_r;
  logic signed [SW-1:0] ax_r, ay_r, az_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start && !busy;
    end
    ax_r <= in_accel_x;
    ay_r <= in_accel_y;
    az_r <= in_accel_z;
  end

  logic                 sq_v_r;
  logic [SQ_W-1:0]      yy_r, zz_r;
  logic signed [SW-1:0] sq_ax_r, sq_ay_r, sq_az_r;
  logic signed [SQ_W-1:0] yy_nxt, zz_nxt;

  always_comb begin
    yy_nxt = ay_r * ay_r;
    zz_nxt = az_r * az_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else begin
      sq_v_r <= in_v_r;
    end
    yy_r    <= $unsigned(yy_nxt);
    zz_r    <= $unsigned(zz_nxt);
    sq_ax_r <= ax_r;
    sq_ay_r <= ay_r;
    sq_az_r <= az_r;
  end

  logic              sum_v_r;
  logic [SQ_W-1:0]   sum_r;
  logic [SIDE_W-1:0] sum_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r <= 1'b0;
    end else begin
      sum_v_r <= sq_v_r;
    end
    sum_r      <= yy_r + zz_r;
    sum_side_r <= {sq_ax_r, sq_ay_r, sq_az_r};
  end

  logic              rt_valid;
  logic [ROOT_W-1:0] rt_root;
  logic [SIDE_W-1:0] rt_side;

  atrp_sqrt #(
    .IN_W   (SQ_W),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sum_v_r),
    .in_sum    (sum_r),
    .in_side   (sum_side_r),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  logic signed [SW-1:0] rt_ax, rt_ay, rt_az;
  logic signed [CW-1:0] roll_x, roll_y, pitch_x, pitch_y, ax_scaled;

  always_comb begin
    rt_ax     = $signed(rt_side[3*SW-1:2*SW]);
    rt_ay     = $signed(rt_side[2*SW-1:SW]);
    rt_az     = $signed(rt_side[SW-1:0]);
    roll_x    = $signed({{(CW-SW-FRAC){rt_az[SW-1]}}, rt_az, {FRAC{1'b0}}});
    roll_y    = $signed({{(CW-SW-FRAC){rt_ay[SW-1]}}, rt_ay, {FRAC{1'b0}}});
    ax_scaled = $signed({{(CW-SW-FRAC){rt_ax[SW-1]}}, rt_ax, {FRAC{1'b0}}});
    pitch_y   = -ax_scaled;
    pitch_x   = $signed({{(CW-ROOT_W){1'b0}}, rt_root});
  end

  logic roll_valid, pitch_valid;

  atrp_cordic #(
    .CW    (CW),
    .STEPS (ROTATION_STEPS),
    .OUT_W (atrp_pkg::ROLL_W),
    .LIMIT (atrp_pkg::ROLL_LIMIT)
  ) u_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rt_valid),
    .in_x      (roll_x),
    .in_y      (roll_y),
    .out_valid (roll_valid),
    .out_angle (out_roll_angle)
  );

  atrp_cordic #(
    .CW    (CW),
    .STEPS (ROTATION_STEPS),
    .OUT_W (atrp_pkg::PITCH_W),
    .LIMIT (atrp_pkg::PITCH_LIMIT)
  ) u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rt_valid),
    .in_x      (pitch_x),
    .in_y      (pitch_y),
    .out_valid (pitch_valid),
    .out_angle (out_pitch_angle)
  );

  assign out_valid = roll_valid && pitch_valid;

endmodule
